// ----- rtl/core/plin_pkg.sv -----
// ----------------------------------------------------------------------------
// plin_pkg
// Shared widths, reset value and the queued job type for the line
// intersection unit.
// ----------------------------------------------------------------------------
package plin_pkg;

    localparam int CW        = 32;
    localparam int FB        = 16;
    localparam int THR_W     = 63;
    localparam logic [THR_W-1:0] THR_RESET = 63'd43;

    localparam int DIFF_W    = CW + 1;
    localparam int PROD_W    = 2 * CW;
    localparam int NPROD_W   = DIFF_W + CW;
    localparam int D_W       = PROD_W + 1;
    localparam int N_W       = NPROD_W + 1;
    localparam int DMAG_W    = PROD_W + 1;
    localparam int NMAG_W    = NPROD_W;
    localparam int NLO_W     = CW + 1;
    localparam int NHI_W     = NMAG_W - NLO_W;
    localparam int PLO_W     = CW + NLO_W;
    localparam int PHI_W     = CW + NHI_W;
    localparam int B2_W      = DMAG_W + 1;
    localparam int QB        = CW + 3;
    localparam int RW        = B2_W + QB;
    localparam int SW        = QB + 2;
    localparam int DIV_DEPTH = QB + 1;

    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [CW-1:0]  pt_x;
        logic signed [CW-1:0]  pt_y;
        logic [CW-1:0]         dmag_x;
        logic [CW-1:0]         dmag_y;
        logic                  dneg_x;
        logic                  dneg_y;
        logic [NMAG_W-1:0]     n_mag;
        logic                  n_neg;
        logic [DMAG_W-1:0]     d_mag;
        logic                  d_neg;
        logic                  par;
    } t_job;

endpackage

// ----- rtl/core/plin_front.sv -----
// ----------------------------------------------------------------------------
// plin_front
// Accepts line pairs, forms the two cross products and classifies each pair
// as parallel or not before handing it to the job queue.
// ----------------------------------------------------------------------------
module plin_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cfg_we,
    input  logic [plin_pkg::THR_W-1:0]        i_cfg_data,
    input  logic signed [plin_pkg::CW-1:0]    i_dir1_x,
    input  logic signed [plin_pkg::CW-1:0]    i_dir1_y,
    input  logic signed [plin_pkg::CW-1:0]    i_pt1_x,
    input  logic signed [plin_pkg::CW-1:0]    i_pt1_y,
    input  logic signed [plin_pkg::CW-1:0]    i_dir2_x,
    input  logic signed [plin_pkg::CW-1:0]    i_dir2_y,
    input  logic signed [plin_pkg::CW-1:0]    i_pt2_x,
    input  logic signed [plin_pkg::CW-1:0]    i_pt2_y,
    input  logic                              i_full,
    output logic                              o_push,
    output plin_pkg::t_job                    o_job
);
    import plin_pkg::*;

    logic [THR_W-1:0]          r_thr;
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic                      en;

    logic signed [CW-1:0]      r_s1_d1x, r_s1_d1y, r_s1_p1x, r_s1_p1y, r_s1_d2x, r_s1_d2y;
    logic signed [DIFF_W-1:0]  r_s1_dx, r_s1_dy;

    logic signed [CW-1:0]      r_s2_d1x, r_s2_d1y, r_s2_p1x, r_s2_p1y;
    logic signed [PROD_W-1:0]  r_pa, r_pb;
    logic signed [NPROD_W-1:0] r_pc, r_pd;

    logic signed [CW-1:0]      r_s3_d1x, r_s3_d1y, r_s3_p1x, r_s3_p1y;
    logic signed [D_W-1:0]     r_d;
    logic signed [N_W-1:0]     r_n;

    t_job                      r_job;
    t_job                      n_job;
    logic signed [N_W-1:0]     d_ext;
    logic signed [N_W-1:0]     thr_pos;
    logic signed [N_W-1:0]     thr_neg;

    assign en      = !(r_v4 && i_full);
    assign o_stall = !en;
    assign o_push  = r_v4 && !i_full;
    assign o_job   = r_job;

    always_comb begin
        d_ext   = N_W'(r_d);
        thr_pos = N_W'({1'b0, r_thr});
        thr_neg = -thr_pos;
        n_job.pt_x   = r_s3_p1x;
        n_job.pt_y   = r_s3_p1y;
        n_job.dneg_x = r_s3_d1x[CW-1];
        n_job.dneg_y = r_s3_d1y[CW-1];
        n_job.dmag_x = r_s3_d1x[CW-1] ? CW'(-r_s3_d1x) : CW'(r_s3_d1x);
        n_job.dmag_y = r_s3_d1y[CW-1] ? CW'(-r_s3_d1y) : CW'(r_s3_d1y);
        n_job.n_neg  = r_n[N_W-1];
        n_job.n_mag  = r_n[N_W-1] ? NMAG_W'(-r_n) : NMAG_W'(r_n);
        n_job.d_neg  = r_d[D_W-1];
        n_job.d_mag  = r_d[D_W-1] ? DMAG_W'(-r_d) : DMAG_W'(r_d);
        n_job.par    = (r_d == '0) || ((d_ext < thr_pos) && (d_ext > thr_neg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d1x <= i_dir1_x;
            r_s1_d1y <= i_dir1_y;
            r_s1_p1x <= i_pt1_x;
            r_s1_p1y <= i_pt1_y;
            r_s1_d2x <= i_dir2_x;
            r_s1_d2y <= i_dir2_y;
            r_s1_dx  <= DIFF_W'(i_pt2_x) - DIFF_W'(i_pt1_x);
            r_s1_dy  <= DIFF_W'(i_pt2_y) - DIFF_W'(i_pt1_y);

            r_s2_d1x <= r_s1_d1x;
            r_s2_d1y <= r_s1_d1y;
            r_s2_p1x <= r_s1_p1x;
            r_s2_p1y <= r_s1_p1y;
            r_pa     <= r_s1_d1y * r_s1_d2x;
            r_pb     <= r_s1_d1x * r_s1_d2y;
            r_pc     <= r_s1_dy * r_s1_d2x;
            r_pd     <= r_s1_dx * r_s1_d2y;

            r_s3_d1x <= r_s2_d1x;
            r_s3_d1y <= r_s2_d1y;
            r_s3_p1x <= r_s2_p1x;
            r_s3_p1y <= r_s2_p1y;
            r_d      <= D_W'(r_pa) - D_W'(r_pb);
            r_n      <= N_W'(r_pc) - N_W'(r_pd);

            r_job    <= n_job;
        end
    end

endmodule

// ----- rtl/core/plin_queue.sv -----
// ----------------------------------------------------------------------------
// plin_queue
// Short job queue between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module plin_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plin_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output plin_pkg::t_job o_job
);
    import plin_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/plin_back.sv -----
// ----------------------------------------------------------------------------
// plin_back
// Scales the numerator by each direction, divides with one quotient bit per
// stage, then adds the point, rounds and saturates into the output register.
// ----------------------------------------------------------------------------
module plin_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  plin_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [plin_pkg::CW-1:0]    o_cross_x,
    output logic signed [plin_pkg::CW-1:0]    o_cross_y,
    output logic                              o_parallel,
    output logic                              o_saturated
);
    import plin_pkg::*;

    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [B2_W-1:0]      b2;
        logic [QB-1:0]        q;
        logic                 ovf;
        logic                 neg;
        logic signed [CW-1:0] pt;
    } t_lane;

    localparam logic signed [SW-1:0] C_MAX = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] C_MIN = -C_MAX - SW'(1);

    logic                      en;
    logic                      r_b1_v;
    logic [PLO_W-1:0]          r_plo [2];
    logic [PHI_W-1:0]          r_phi [2];
    logic signed [CW-1:0]      r_b1_pt [2];
    logic                      r_b1_neg [2];
    logic [DMAG_W-1:0]         r_b1_d;
    logic                      r_b1_par;

    logic                      r_dv  [DIV_DEPTH+1];
    logic                      r_par [DIV_DEPTH+1];
    t_lane                     r_lane [DIV_DEPTH+1][2];
    t_lane                     n_lane [DIV_DEPTH+1][2];

    logic                      r_o_valid;
    logic signed [CW-1:0]      r_cx, r_cy;
    logic                      r_par_o, r_sat_o;
    logic signed [CW-1:0]      n_c [2];
    logic                      n_s [2];
    logic signed [SW-1:0]      qs  [2];
    logic signed [SW-1:0]      sum [2];

    assign en          = !(r_o_valid && i_stall);
    assign o_pop       = en && !i_empty;
    assign o_valid     = r_o_valid;
    assign o_cross_x   = r_cx;
    assign o_cross_y   = r_cy;
    assign o_parallel  = r_par_o;
    assign o_saturated = r_sat_o;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_lane[0][c].rem = (RW'(r_plo[c]) << 1) + (RW'(r_phi[c]) << (NLO_W + 1))
                               + RW'(r_b1_d);
            n_lane[0][c].b2  = {r_b1_d, 1'b0};
            n_lane[0][c].q   = '0;
            n_lane[0][c].ovf = 1'b0;
            n_lane[0][c].neg = r_b1_neg[c];
            n_lane[0][c].pt  = r_b1_pt[c];
        end
    end

    for (genvar j = 0; j < DIV_DEPTH; j++) begin : g_div
        if (j == 0) begin : g_ovf
            always_comb begin
                for (int c = 0; c < 2; c++) begin
                    n_lane[j+1][c]     = r_lane[j][c];
                    n_lane[j+1][c].ovf = r_lane[j][c].rem >= (RW'(r_lane[j][c].b2) << QB);
                end
            end
        end else begin : g_bit
            always_comb begin
                for (int c = 0; c < 2; c++) begin
                    n_lane[j+1][c] = r_lane[j][c];
                    if (r_lane[j][c].rem >= (RW'(r_lane[j][c].b2) << (QB - j))) begin
                        n_lane[j+1][c].rem = r_lane[j][c].rem
                                             - (RW'(r_lane[j][c].b2) << (QB - j));
                        n_lane[j+1][c].q[QB-j] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            qs[c]  = r_lane[DIV_DEPTH][c].neg ? -SW'(r_lane[DIV_DEPTH][c].q)
                                               :  SW'(r_lane[DIV_DEPTH][c].q);
            sum[c] = SW'(r_lane[DIV_DEPTH][c].pt) + qs[c];
            priority if (r_lane[DIV_DEPTH][c].ovf) begin
                n_c[c] = r_lane[DIV_DEPTH][c].neg ? CW'(C_MIN) : CW'(C_MAX);
                n_s[c] = 1'b1;
            end else if (sum[c] > C_MAX) begin
                n_c[c] = CW'(C_MAX);
                n_s[c] = 1'b1;
            end else if (sum[c] < C_MIN) begin
                n_c[c] = CW'(C_MIN);
                n_s[c] = 1'b1;
            end else begin
                n_c[c] = CW'(sum[c]);
                n_s[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v    <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j <= DIV_DEPTH; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (en) begin
            r_b1_v  <= o_pop;
            r_dv[0] <= r_b1_v;
            for (int j = 1; j <= DIV_DEPTH; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
            r_o_valid <= r_dv[DIV_DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plo[0]    <= i_job.dmag_x * i_job.n_mag[NLO_W-1:0];
            r_phi[0]    <= i_job.dmag_x * i_job.n_mag[NMAG_W-1:NLO_W];
            r_plo[1]    <= i_job.dmag_y * i_job.n_mag[NLO_W-1:0];
            r_phi[1]    <= i_job.dmag_y * i_job.n_mag[NMAG_W-1:NLO_W];
            r_b1_pt[0]  <= i_job.pt_x;
            r_b1_pt[1]  <= i_job.pt_y;
            r_b1_neg[0] <= i_job.dneg_x ^ i_job.n_neg ^ i_job.d_neg;
            r_b1_neg[1] <= i_job.dneg_y ^ i_job.n_neg ^ i_job.d_neg;
            r_b1_d      <= i_job.d_mag;
            r_b1_par    <= i_job.par;

            r_par[0]  <= r_b1_par;
            r_lane[0] <= n_lane[0];
            for (int j = 1; j <= DIV_DEPTH; j++) begin
                r_par[j]  <= r_par[j-1];
                r_lane[j] <= n_lane[j];
            end

            if (r_par[DIV_DEPTH]) begin
                r_cx    <= '0;
                r_cy    <= '0;
                r_par_o <= 1'b1;
                r_sat_o <= 1'b0;
            end else begin
                r_cx    <= n_c[0];
                r_cy    <= n_c[1];
                r_par_o <= 1'b0;
                r_sat_o <= n_s[0] | n_s[1];
            end
        end
    end

endmodule

// ----- rtl/core/parametric_line_intersection_unit.sv -----
// ----------------------------------------------------------------------------
// parametric_line_intersection_unit
// Intersection of two 2D lines given as direction and point in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with the eight line fields. A pair is
//   taken at a clock edge where i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with intersection x/y, parallel and
//   saturated flags; a result moves where o_valid is high and i_stall low.
//   Configuration: i_cfg_we writes i_cfg_data into the parallel threshold
//   (unsigned Q31.32 magnitude); write only while no transaction is in flight.
//   Throughput: one transaction per cycle while i_stall stays low; the
//   pipelined bit-per-stage divider retires one quotient per cycle.
//   Pipeline from input to output: 4 front stages, queue, multiply stage,
//   37 divider stages, output register.
//   Reset clears all valid state and loads the threshold with 43.
//   When the receiver stalls the back pipeline holds; the four-entry queue
//   absorbs the front until full, after which o_stall rises.
// ----------------------------------------------------------------------------
module parametric_line_intersection_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cfg_we,
    input  logic [plin_pkg::THR_W-1:0]        i_cfg_data,
    input  logic signed [plin_pkg::CW-1:0]    i_dir1_x,
    input  logic signed [plin_pkg::CW-1:0]    i_dir1_y,
    input  logic signed [plin_pkg::CW-1:0]    i_pt1_x,
    input  logic signed [plin_pkg::CW-1:0]    i_pt1_y,
    input  logic signed [plin_pkg::CW-1:0]    i_dir2_x,
    input  logic signed [plin_pkg::CW-1:0]    i_dir2_y,
    input  logic signed [plin_pkg::CW-1:0]    i_pt2_x,
    input  logic signed [plin_pkg::CW-1:0]    i_pt2_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [plin_pkg::CW-1:0]    o_cross_x,
    output logic signed [plin_pkg::CW-1:0]    o_cross_y,
    output logic                              o_parallel,
    output logic                              o_saturated
);
    import plin_pkg::*;

    logic push, pop, full, empty;
    t_job job_in, job_out;

    plin_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_dir1_x   (i_dir1_x),
        .i_dir1_y   (i_dir1_y),
        .i_pt1_x    (i_pt1_x),
        .i_pt1_y    (i_pt1_y),
        .i_dir2_x   (i_dir2_x),
        .i_dir2_y   (i_dir2_y),
        .i_pt2_x    (i_pt2_x),
        .i_pt2_y    (i_pt2_y),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job_in)
    );

    plin_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    plin_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cross_x   (o_cross_x),
        .o_cross_y   (o_cross_y),
        .o_parallel  (o_parallel),
        .o_saturated (o_saturated)
    );

endmodule

// ----- rtl/core/plin_checker.sv -----
// ----------------------------------------------------------------------------
// plin_checker
// Port-level checks on the intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module plin_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic signed [plin_pkg::CW-1:0]    o_cross_x,
    input  logic signed [plin_pkg::CW-1:0]    o_cross_y,
    input  logic                              o_parallel,
    input  logic                              o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cross_x) && $stable(o_cross_y))
        else $error("stalled result changed");

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parallel |-> o_cross_x == '0 && o_cross_y == '0 && !o_saturated)
        else $error("parallel result not zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind parametric_line_intersection_unit plin_checker u_plin_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_cross_x   (o_cross_x),
    .o_cross_y   (o_cross_y),
    .o_parallel  (o_parallel),
    .o_saturated (o_saturated)
);
